// ----- rtl/kmc_pkg.sv -----
// shared constants, codes and types of the kruskal maze carver
package kmc_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int FRAC_BITS  = 16;
  localparam int GRID_W     = 7;
  localparam int COORD_W    = $clog2(MAX_SIDE);
  localparam int CELL_W     = 2 * COORD_W;
  localparam int CELLS      = MAX_SIDE * MAX_SIDE;
  localparam int WALL_DEPTH = 2 * CELLS;
  localparam int WADDR_W    = $clog2(WALL_DEPTH);
  localparam int LEN_W      = WADDR_W + 1;
  localparam int WALL_W     = 2 * COORD_W + 1;
  localparam int PROD_W     = FRAC_BITS + LEN_W;
  localparam int R_W        = PROD_W - FRAC_BITS - 1;

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_NOTHING = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_FILL,
    OP_ROW,
    OP_MUL,
    OP_POS,
    OP_RD_ENT,
    OP_GET_ENT,
    OP_SH_RD,
    OP_SH_WR,
    OP_SHRINK,
    OP_FA_RD,
    OP_FA_CHK,
    OP_FB_RD,
    OP_FB_CHK,
    OP_UNITE,
    OP_RESULT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_ROW,
    S_MUL,
    S_POS,
    S_RD_ENT,
    S_GET_ENT,
    S_SHIFT,
    S_SH_WR,
    S_FA_RD,
    S_FA_CHK,
    S_FB_RD,
    S_FB_CHK,
    S_UNITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic start_ok;
    logic pick_ok;
    logic fill_last;
    logic row_done;
    logic shift_done;
    logic root_hit;
  } dp_status_t;

endpackage

// ----- rtl/kmc_ram.sv -----
// generic single write port ram with registered read
module kmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/kmc_datapath.sv -----
// datapath: config registers, wall list, set parents, counters and result register
module kmc_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_index_i,
  input  logic [kmc_pkg::GRID_W-1:0] cfg_data_i,
  input  logic                     mode_i,
  input  logic                     coin_i,
  input  logic [kmc_pkg::FRAC_BITS-1:0] fraction_i,
  input  kmc_pkg::op_e             op_i,
  output kmc_pkg::dp_status_t      status_o,
  output logic [1:0]               res_status_o,
  output logic [kmc_pkg::COORD_W-1:0] res_x_o,
  output logic [kmc_pkg::COORD_W-1:0] res_y_o,
  output logic                     res_vertical_o,
  output logic                     res_removed_o,
  output logic                     res_finished_o
);
  import kmc_pkg::*;

  logic [GRID_W-1:0]    grid_w_q, grid_h_q;
  logic                 coin_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [COORD_W-1:0]   wm1_q, hm1_q, x_q, y_q;
  logic                 sub_q;
  logic [LEN_W-1:0]     len_q;
  logic [CELL_W-1:0]    unions_q;
  logic [PROD_W-1:0]    prod_q;
  logic [WADDR_W-1:0]   pos_q, idx_q;
  logic [COORD_W-1:0]   ent_x_q, ent_y_q;
  logic                 ent_v_q, removed_q;
  status_e              st_q;
  logic [CELL_W-1:0]    cur_q, ra_q;

  logic [1:0]           out_status_q;
  logic [COORD_W-1:0]   out_x_q, out_y_q;
  logic                 out_v_q, out_rm_q, out_fin_q;

  logic                 grid_ok;
  logic [COORD_W-1:0]   cw, ch;
  logic                 w_we, p_we;
  logic [WADDR_W-1:0]   w_waddr, w_raddr;
  logic [WALL_W-1:0]    w_wdata, w_rdata;
  logic [CELL_W-1:0]    p_waddr, p_wdata, p_rdata;
  logic                 push_east, push_south;
  logic [R_W-1:0]       r_val, off_val;
  logic [LEN_W-1:0]     len_m1, off_c, pos_full;
  logic [CELL_W-1:0]    cell_a, cell_b;

  assign grid_ok = (grid_w_q > GRID_W'(1)) && (grid_h_q > GRID_W'(1))
                && (grid_w_q <= GRID_W'(MAX_SIDE)) && (grid_h_q <= GRID_W'(MAX_SIDE));
  assign cw = grid_w_q[COORD_W-1:0] - COORD_W'(1);
  assign ch = grid_h_q[COORD_W-1:0] - COORD_W'(1);

  assign push_east  = !sub_q && (x_q < wm1_q) && (y_q < hm1_q);
  assign push_south = sub_q && (y_q < hm1_q);

  assign r_val   = prod_q[PROD_W-1:FRAC_BITS+1];
  assign off_val = (r_val != '0) ? r_val - R_W'(1) : '0;
  assign len_m1  = len_q - LEN_W'(1);
  assign off_c   = (LEN_W'(off_val) > len_m1) ? len_m1 : LEN_W'(off_val);
  assign pos_full = coin_q ? off_c : len_m1 - off_c;

  assign cell_a = {ent_y_q, ent_x_q};
  assign cell_b = ent_v_q ? {ent_y_q, ent_x_q + COORD_W'(1)}
                          : {ent_y_q + COORD_W'(1), ent_x_q};

  assign status_o.start_ok   = !mode_i && grid_ok;
  assign status_o.pick_ok    = mode_i && (unions_q != '0) && (len_q != '0);
  assign status_o.fill_last  = sub_q && (x_q == wm1_q) && (y_q == hm1_q);
  assign status_o.row_done   = (x_q >= wm1_q);
  assign status_o.shift_done = (LEN_W'(idx_q) + LEN_W'(1)) >= len_q;
  assign status_o.root_hit   = (p_rdata == cur_q);

  // memory port selection
  always_comb begin
    w_we    = 1'b0;
    w_waddr = len_q[WADDR_W-1:0];
    w_wdata = {x_q, y_q, 1'b1};
    w_raddr = pos_q;
    p_we    = 1'b0;
    p_waddr = {y_q, x_q};
    p_wdata = {y_q, x_q};
    case (op_i)
      OP_FILL: begin
        p_we = !sub_q;
        w_we = push_east || push_south;
        w_wdata = {x_q, y_q, !sub_q};
      end
      OP_ROW: begin
        w_we = !status_o.row_done;
        w_wdata = {x_q, hm1_q, 1'b1};
      end
      OP_SH_RD: w_raddr = idx_q + WADDR_W'(1);
      OP_SH_WR: begin
        w_we    = 1'b1;
        w_waddr = idx_q;
        w_wdata = w_rdata;
      end
      OP_UNITE: begin
        p_we    = (ra_q != cur_q);
        p_waddr = ra_q;
        p_wdata = cur_q;
      end
      default: ;
    endcase
  end

  kmc_ram #(.Width(WALL_W), .Depth(WALL_DEPTH)) u_walls (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  kmc_ram #(.Width(CELL_W), .Depth(CELLS)) u_parents (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (cur_q),
    .rdata_o (p_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GRID_W'(16);
      grid_h_q <= GRID_W'(16);
      len_q    <= '0;
      unions_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GRID_WIDTH:  grid_w_q <= cfg_data_i;
          CFG_GRID_HEIGHT: grid_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (op_i)
        OP_LOAD: begin
          if (status_o.start_ok) begin
            len_q    <= '0;
            unions_q <= CELL_W'(cw) * CELL_W'(ch) - CELL_W'(1);
          end
        end
        OP_FILL, OP_ROW: if (w_we) len_q <= len_q + LEN_W'(1);
        OP_SHRINK: len_q <= len_m1;
        OP_UNITE: if (ra_q != cur_q) unions_q <= unions_q - CELL_W'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        coin_q    <= coin_i;
        frac_q    <= fraction_i;
        wm1_q     <= cw;
        hm1_q     <= ch;
        x_q       <= COORD_W'(1);
        y_q       <= COORD_W'(1);
        sub_q     <= 1'b0;
        ent_x_q   <= '0;
        ent_y_q   <= '0;
        ent_v_q   <= 1'b0;
        removed_q <= 1'b0;
        if (mode_i) st_q <= status_o.pick_ok ? ST_OK : ST_NOTHING;
        else        st_q <= grid_ok ? ST_OK : ST_BAD;
      end
      OP_FILL: begin
        sub_q <= !sub_q;
        if (status_o.fill_last) begin
          x_q <= COORD_W'(1);
        end else if (sub_q) begin
          if (y_q == hm1_q) begin
            y_q <= COORD_W'(1);
            x_q <= x_q + COORD_W'(1);
          end else begin
            y_q <= y_q + COORD_W'(1);
          end
        end
      end
      OP_ROW: if (!status_o.row_done) x_q <= x_q + COORD_W'(1);
      OP_MUL: prod_q <= PROD_W'(frac_q) * PROD_W'(len_q);
      OP_POS: pos_q <= pos_full[WADDR_W-1:0];
      OP_GET_ENT: begin
        {ent_x_q, ent_y_q, ent_v_q} <= w_rdata;
        idx_q <= pos_q;
      end
      OP_SH_WR: idx_q <= idx_q + WADDR_W'(1);
      OP_SHRINK: cur_q <= cell_a;
      OP_FA_CHK: begin
        if (status_o.root_hit) begin
          ra_q  <= cur_q;
          cur_q <= cell_b;
        end else begin
          cur_q <= p_rdata;
        end
      end
      OP_FB_CHK: if (!status_o.root_hit) cur_q <= p_rdata;
      OP_UNITE: removed_q <= (ra_q != cur_q);
      OP_RESULT: begin
        out_status_q <= st_q;
        out_x_q      <= ent_x_q;
        out_y_q      <= ent_y_q;
        out_v_q      <= ent_v_q;
        out_rm_q     <= removed_q;
        out_fin_q    <= (unions_q == '0);
      end
      default: ;
    endcase
  end

  assign res_status_o   = out_status_q;
  assign res_x_o        = out_x_q;
  assign res_y_o        = out_y_q;
  assign res_vertical_o = out_v_q;
  assign res_removed_o  = out_rm_q;
  assign res_finished_o = out_fin_q;

endmodule

// ----- rtl/kmc_ctrl.sv -----
// controller: sequencing state machine and output valid
module kmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  kmc_pkg::dp_status_t status_i,
  output kmc_pkg::op_e        op_o
);
  import kmc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_o        = OP_IDLE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LOAD;
          if (status_i.start_ok)     state_d = S_FILL;
          else if (status_i.pick_ok) state_d = S_MUL;
          else                       state_d = S_DONE;
        end
      end
      S_FILL: begin
        op_o = OP_FILL;
        if (status_i.fill_last) state_d = S_ROW;
      end
      S_ROW: begin
        if (status_i.row_done) state_d = S_DONE;
        else                   op_o = OP_ROW;
      end
      S_MUL: begin
        op_o    = OP_MUL;
        state_d = S_POS;
      end
      S_POS: begin
        op_o    = OP_POS;
        state_d = S_RD_ENT;
      end
      S_RD_ENT: begin
        op_o    = OP_RD_ENT;
        state_d = S_GET_ENT;
      end
      S_GET_ENT: begin
        op_o    = OP_GET_ENT;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (status_i.shift_done) begin
          op_o    = OP_SHRINK;
          state_d = S_FA_RD;
        end else begin
          op_o    = OP_SH_RD;
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        op_o    = OP_SH_WR;
        state_d = S_SHIFT;
      end
      S_FA_RD: begin
        op_o    = OP_FA_RD;
        state_d = S_FA_CHK;
      end
      S_FA_CHK: begin
        op_o    = OP_FA_CHK;
        state_d = status_i.root_hit ? S_FB_RD : S_FA_RD;
      end
      S_FB_RD: begin
        op_o    = OP_FB_RD;
        state_d = S_FB_CHK;
      end
      S_FB_CHK: begin
        op_o    = OP_FB_CHK;
        state_d = status_i.root_hit ? S_UNITE : S_FB_RD;
      end
      S_UNITE: begin
        op_o    = OP_UNITE;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          op_o        = OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/kruskal_maze_carver_unit.sv -----
// top level of the kruskal maze carver
//
// channel | direction | handshake               | payload
// input   | in        | in_valid_i / in_stall_o | mode_i, coin_i, fraction_i
// result  | out       | out_valid_o / out_stall_i | status_o, wall_x_o, wall_y_o,
//         |           |                         | wall_vertical_o, wall_removed_o, finished_o
// config  | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one transaction at a time; a start sweeps the grid, writing its walls into the
// wall ram one at a time during the fill sweep
// in a pick, the list close-up and the parent walks each alternate a ram read
// state with a state that uses the read data
// bad size or nothing-left transactions go straight from the load to the result state
// reset clears control state and counters; wall and parent rams hold nothing until a start
// a held result sits in the output register while the next transaction is accepted;
// that one then waits in its last state until the output register is free
module kruskal_maze_carver_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [kmc_pkg::GRID_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic                        coin_i,
  input  logic [kmc_pkg::FRAC_BITS-1:0] fraction_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [kmc_pkg::COORD_W-1:0] wall_x_o,
  output logic [kmc_pkg::COORD_W-1:0] wall_y_o,
  output logic                        wall_vertical_o,
  output logic                        wall_removed_o,
  output logic                        finished_o
);
  import kmc_pkg::*;

  op_e        op;
  dp_status_t dp_status;

  // sequencing: fill sweep, pick, list close-up, two root walks, union
  kmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .op_o        (op)
  );

  // storage, arithmetic and the result register
  kmc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (mode_i),
    .coin_i         (coin_i),
    .fraction_i     (fraction_i),
    .op_i           (op),
    .status_o       (dp_status),
    .res_status_o   (status_o),
    .res_x_o        (wall_x_o),
    .res_y_o        (wall_y_o),
    .res_vertical_o (wall_vertical_o),
    .res_removed_o  (wall_removed_o),
    .res_finished_o (finished_o)
  );

endmodule

// ----- rtl/kmc_checker.sv -----
// port level checks of the kruskal maze carver, bound to the top level
module kmc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [5:0] wall_x_o,
  input logic [5:0] wall_y_o,
  input logic       wall_removed_o
);
  import kmc_pkg::*;

  // a held result keeps its status
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");

  // a crushed wall only on a processed pick
  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wall_removed_o |-> status_o == ST_OK)
    else $error("wall removed on an error result");

  // an error result carries no wall
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BAD || status_o == ST_NOTHING)
      |-> wall_x_o == '0 && wall_y_o == '0)
    else $error("error result carries a wall");

  // an accepted transaction keeps the input stalled while it runs
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

endmodule

bind kruskal_maze_carver_unit kmc_checker u_kmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .wall_x_o       (wall_x_o),
  .wall_y_o       (wall_y_o),
  .wall_removed_o (wall_removed_o)
);

// ----- dv/testbench.sv -----
// testbench of the kruskal maze carver: predicts every result and checks it
`timescale 1ns / 1ps

class maze_scoreboard;
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] wx;
    logic [5:0] wy;
    logic       wv;
    logic       removed;
    logic       finished;
  } carve_result_t;

  typedef struct packed {
    logic [5:0] x;
    logic [5:0] y;
    logic       east;
  } wall_t;

  wall_t         walls[$];
  logic [11:0]   parent[4096];
  int unsigned   joins_left;
  int unsigned   width, height;
  carve_result_t pending[$];
  int            errors;

  function new();
    width = 16;
    height = 16;
    joins_left = 0;
    errors = 0;
  endfunction

  function int unsigned cell_of(int unsigned x, int unsigned y);
    return (y * 64 + x) % 4096;
  endfunction

  function int unsigned root_of(int unsigned c);
    int unsigned n;
    for (n = 0; n < 4096; n++) begin
      if (parent[c] == c) break;
      c = parent[c];
    end
    return c;
  endfunction

  function void set_reg(kmc_pkg::cfg_idx_e idx, int unsigned val);
    if (idx == kmc_pkg::CFG_GRID_WIDTH) width = val & 7'h7f;
    else height = val & 7'h7f;
  endfunction

  function void add_wall(int unsigned x, int unsigned y, bit east);
    walls.insert(walls.size(), wall_t'{6'(x), 6'(y), east});
  endfunction

  // note an accepted input transaction and queue what it should produce
  function void note_input(bit mode, bit coin, logic [15:0] frac);
    carve_result_t res;
    longint unsigned len, r, off, pos;
    int unsigned a, b, ra, rb;
    wall_t e;
    res = '0;
    if (mode == 1'b0) begin
      if (width <= 1 || height <= 1 || width > 64 || height > 64) begin
        res.status = kmc_pkg::ST_BAD;
      end else begin
        walls.delete();
        for (int x = 1; x + 1 < width; x++)
          for (int y = 1; y + 1 < height; y++) begin
            add_wall(x, y, 1'b1);
            add_wall(x, y, 1'b0);
          end
        for (int y = 1; y + 1 < height; y++) add_wall(width - 1, y, 1'b0);
        for (int x = 1; x + 1 < width; x++) add_wall(x, height - 1, 1'b1);
        for (int y = 1; y < height; y++)
          for (int x = 1; x < width; x++) parent[cell_of(x, y)] = cell_of(x, y);
        joins_left = (width - 1) * (height - 1) - 1;
      end
    end else if (joins_left == 0 || walls.size() == 0) begin
      res.status = kmc_pkg::ST_NOTHING;
    end else begin
      len = walls.size();
      r = ((longint'(frac) * len) >> 16) >> 1;
      off = (r > 0) ? r - 1 : 0;
      if (off > len - 1) off = len - 1;
      pos = coin ? off : len - 1 - off;
      e = walls[pos];
      walls.delete(pos);
      a = cell_of(e.x, e.y);
      b = e.east ? cell_of(e.x + 1, e.y) : cell_of(e.x, e.y + 1);
      ra = root_of(a);
      rb = root_of(b);
      if (ra != rb) begin
        parent[ra] = rb;
        joins_left--;
        res.removed = 1'b1;
      end
      res.wx = e.x;
      res.wy = e.y;
      res.wv = e.east;
    end
    res.finished = (joins_left == 0);
    pending.insert(pending.size(), res);
  endfunction

  task report(string what, int unsigned got, int unsigned want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(logic [1:0] st, logic [5:0] wx, logic [5:0] wy,
                    logic wv, logic rm, logic fin);
    carve_result_t e;
    if (pending.size() == 0) begin
      report("unexpected result, status", st, 0);
      return;
    end
    e = pending.pop_front();
    if (st !== e.status) report("status", st, e.status);
    if (wx !== e.wx) report("wall_x", wx, e.wx);
    if (wy !== e.wy) report("wall_y", wy, e.wy);
    if (wv !== e.wv) report("wall_vertical", wv, e.wv);
    if (rm !== e.removed) report("wall_removed", rm, e.removed);
    if (fin !== e.finished) report("finished", fin, e.finished);
  endtask
endclass

module testbench;
  import kmc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic        coin_i = 1'b0;
  logic [15:0] fraction_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  wall_x_o, wall_y_o;
  logic        wall_vertical_o, wall_removed_o, finished_o;

  maze_scoreboard board = new();
  int  send_idle_pct = 0;     // chance in a hundred that the sender leaves a gap
  int  stall_pct = 0;         // chance in a hundred that the receiver stalls
  bit  hold_off = 1'b0;       // long receiver hold-off request
  int  quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  kruskal_maze_carver_unit i_dut (.*);

  // receiver: random stalls, plus a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
      repeat (3000) @(posedge clk_i);
      hold_off = 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // results are sampled at the edge where the transaction completes
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(status_o, wall_x_o, wall_y_o, wall_vertical_o,
                         wall_removed_o, finished_o);
  end

  // watchdog: cycles with no accepted transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one input transaction and wait until it is taken; valid stays up
  // afterwards, the block stalls while busy and the next offer replaces it
  task automatic send_item(bit mode, bit coin, logic [15:0] frac);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    coin_i <= coin;
    fraction_i <= frac;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(mode, coin, frac);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // register writes only while the block is idle
  task automatic write_grid(int unsigned w, int unsigned h);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_GRID_WIDTH;
    cfg_data_i <= 7'(w);
    @(posedge clk_i);
    board.set_reg(CFG_GRID_WIDTH, w);
    cfg_index_i <= CFG_GRID_HEIGHT;
    cfg_data_i <= 7'(h);
    @(posedge clk_i);
    board.set_reg(CFG_GRID_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  // one maze: a start and then picks, mostly until finished
  task automatic carve(int picks);
    send_item(1'b0, $urandom_range(1), $urandom);
    for (int i = 0; i < picks; i++) send_item(1'b1, $urandom_range(1), $urandom);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: picks before any start, small, bad and largest grids, field extremes
    send_item(1'b1, 1'b0, 16'h0000);
    send_item(1'b1, 1'b1, 16'hffff);
    write_grid(2, 2);                       // single cell: finished at once
    carve(2);
    write_grid(1, 5);                       // bad width
    send_item(1'b0, 1'b0, 16'h0);
    write_grid(5, 0);                       // bad height
    send_item(1'b0, 1'b1, 16'hffff);
    write_grid(65, 3);                      // over the maximum
    send_item(1'b0, 1'b0, 16'h0);
    write_grid(3, 3);
    send_item(1'b0, 1'b0, 16'h0);
    send_item(1'b1, 1'b1, 16'hffff);
    send_item(1'b1, 1'b0, 16'hffff);
    send_item(1'b1, 1'b1, 16'h0000);
    send_item(1'b1, 1'b0, 16'h0000);
    send_item(1'b1, 1'b1, 16'h8000);
    send_item(1'b1, 1'b0, 16'h5555);
    write_grid(64, 64);                     // largest grid, a few picks
    carve(3);

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 53 : 0;
      stall_pct = (ph == 2) ? 53 : (ph == 3) ? 11 : 0;
      if (ph == 3) send_idle_pct = 11;
      write_grid($urandom_range(2, 6), $urandom_range(2, 6));
      carve($urandom_range(15, 30));
      if (ph == 1) begin
        hold_off = 1'b1;
        carve(6);
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
